// ===== hw/rtl/vsd_pkg.sv =====
// Shared types and constants for the vehicle switch debouncer.
`timescale 1ns / 1ps

package vsd_pkg;

	localparam int NUM_CH = 5;

	typedef logic [2:0] ch_t;

	localparam ch_t CH_LEFT   = 3'd0;
	localparam ch_t CH_RIGHT  = 3'd1;
	localparam ch_t CH_PARKED = 3'd2;
	localparam ch_t CH_AIRBAG = 3'd3;
	localparam ch_t CH_HORN   = 3'd4;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

	// One edge event.
	typedef struct packed {
		ch_t         channel;
		logic        level_active;
		logic [31:0] now_ms;
	} item_t;

	// One result: event outcome plus all switch states (bit i = channel i).
	typedef struct packed {
		logic              event_valid;
		ch_t               event_channel;
		logic              event_state;
		logic [NUM_CH-1:0] sw;
	} res_t;

endpackage

// ===== hw/rtl/vsd_core.sv =====
// Debounce decision logic with switch state, timestamps and debounce register.
`timescale 1ns / 1ps

module vsd_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          step,
	input  vsd_pkg::item_t item,
	output vsd_pkg::res_t  res
);
	import vsd_pkg::*;

	logic [15:0]       debounce_q;
	logic [NUM_CH-1:0] sw_q;
	logic [NUM_CH-1:0] ever_q;
	logic [31:0]       last_q [NUM_CH];

	logic [NUM_CH-1:0] sw_next;
	logic [31:0]       last_sel;
	logic [31:0]       elapsed;
	logic              too_soon;
	logic              acc;
	logic              new_state;
	logic              cur;
	logic              blocked;
	logic              valid_ch;

	assign valid_ch = (item.channel == CH_LEFT) || (item.channel == CH_RIGHT) ||
		(item.channel == CH_PARKED) || (item.channel == CH_AIRBAG) ||
		(item.channel == CH_HORN);

	assign last_sel = valid_ch ? last_q[item.channel] : '0;
	// Modulo 2^32 difference handles tick wraparound.
	assign elapsed  = item.now_ms - last_sel;
	assign too_soon = elapsed < {16'd0, debounce_q};
	assign cur      = valid_ch ? sw_q[item.channel] : 1'b0;
	assign blocked  = item.level_active && valid_ch && ever_q[item.channel] && too_soon;

	always_comb begin
		sw_next   = sw_q;
		acc       = 1'b0;
		new_state = 1'b0;
		case (item.channel)
			CH_LEFT, CH_RIGHT, CH_HORN: begin
				if ((cur != item.level_active) && !blocked) begin
					acc       = 1'b1;
					new_state = item.level_active;
					sw_next[item.channel] = item.level_active;
					// turn signals are mutually exclusive
					if (item.level_active && (item.channel == CH_LEFT)) begin
						sw_next[CH_RIGHT] = 1'b0;
					end else if (item.level_active && (item.channel == CH_RIGHT)) begin
						sw_next[CH_LEFT] = 1'b0;
					end
				end
			end
			CH_PARKED, CH_AIRBAG: begin
				if (!too_soon) begin
					acc       = 1'b1;
					new_state = ~cur;
					sw_next[item.channel] = ~cur;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.event_valid   = acc;
		res.event_channel = acc ? item.channel : CH_LEFT;
		res.event_state   = acc & new_state;
		res.sw            = sw_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= '0;
			ever_q <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				last_q[i] <= '0;
			end
		end else if (step) begin
			sw_q <= sw_next;
			if (acc) begin
				ever_q[item.channel] <= 1'b1;
				last_q[item.channel] <= item.now_ms;
			end
		end
	end

	a_turn_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sw_q[CH_LEFT] && sw_q[CH_RIGHT]))
		else $error("left and right signals both on");

	a_state_follows: assert property (@(posedge clk) disable iff (!arst_n)
		step && acc |=> sw_q[$past(item.channel)] == $past(new_state))
		else $error("accepted event did not update switch state");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		step && !acc |=> $stable(sw_q) && $stable(ever_q))
		else $error("rejected event changed state");

endmodule

// ===== hw/rtl/vehicle_switch_debouncer_unit.sv =====
// Top level of the vehicle switch debouncer: input stage, decision core, result register.
`timescale 1ns / 1ps

// Vehicle switch debouncer.
// Input channel (in_valid/in_ready): one edge event per transaction, carrying
// channel (0 left, 1 right, 2 parked, 3 airbag, 4 horn), level_active and a
// wrapping millisecond timestamp now_ms.
// Output channel (out_valid/out_ready): exactly one result per input
// transaction, in order: event_valid/event_channel/event_state for the event
// outcome and the five switch states after the event.
// Config channel (cfg_valid/cfg_ready): writes debounce_time (ms) from
// cfg_data; always ready. Write only while no event is in flight.
// An accepted event sits in the input stage, is decided by the core and
// is registered in the result register, from which its result is offered.
// Throughput: one event per cycle unless the output stalls. The decision
// (one 32-bit subtract, one compare, a five-bit state update) runs
// combinationally between the input stage and the result register, and
// state written at one edge is seen by the event behind it.
// Stall: while out_ready is low the result holds, the input stage fills,
// and in_ready drops only once both are full.
// Reset: all switches off, timestamps zero, debounce_time 50 ms.
module vehicle_switch_debouncer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vsd_pkg::ch_t        channel,
	input  logic                level_active,
	input  logic [31:0]         now_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                event_valid,
	output vsd_pkg::ch_t        event_channel,
	output logic                event_state,
	output logic                left_on,
	output logic                right_on,
	output logic                parked_on,
	output logic                airbag_on,
	output logic                horn_on,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import vsd_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  valid_s2;
	res_t  res_s2;
	res_t  res;
	logic  advance;
	logic  step;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.channel      <= channel;
			item_s1.level_active <= level_active;
			item_s1.now_ms       <= now_ms;
		end
	end

	vsd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_wdata(cfg_data),
		.step     (step),
		.item     (item_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign event_valid   = res_s2.event_valid;
	assign event_channel = res_s2.event_channel;
	assign event_state   = res_s2.event_state;
	assign left_on       = res_s2.sw[CH_LEFT];
	assign right_on      = res_s2.sw[CH_RIGHT];
	assign parked_on     = res_s2.sw[CH_PARKED];
	assign airbag_on     = res_s2.sw[CH_AIRBAG];
	assign horn_on       = res_s2.sw[CH_HORN];

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("decided event lost before result register");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.event_valid |-> res_s2.event_channel == CH_LEFT &&
			!res_s2.event_state)
		else $error("rejected event carries channel or state");

endmodule
